/* design/ddm_pkg.sv */
// Shared types and constants for the differential-drive mixer with obstacle stop.
// Request/result payload structs, controller/datapath command and status structs.
// No dependencies.
package ddm_pkg;

    localparam int SPEED_WIDTH = 24;             // wheel speed setpoint width
    localparam int VEL_W       = 24;             // velocity command width
    localparam int LEN_W       = 16;             // Q4.12 lengths and ranges
    localparam int LIMIT_W     = 23;             // speed_limit register width
    localparam int CFG_DATA_W  = 23;             // widest config register
    localparam int CFG_IDX_W   = 3;
    localparam int VS_SHIFT    = 13;             // v scaled to Q.25
    localparam int PROD_W      = VEL_W + LEN_W;  // w * axle
    localparam int NUM_W       = PROD_W + 1;     // numerator after add
    localparam int DIV_W       = LEN_W + 1;      // 2 * wheel radius
    localparam int DIV_STEPS   = NUM_W;          // one quotient bit per step
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);
    localparam int LIM_W       = SPEED_WIDTH - 1;

    // request action codes
    localparam logic ACT_VEL   = 1'b0;           // velocity command
    localparam logic ACT_RANGE = 1'b1;           // range reading

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXLE     = 3'd0,
        REG_RADIUS   = 3'd1,
        REG_LIMIT    = 3'd2,
        REG_STOPBAND = 3'd3,
        REG_OBSTDIST = 3'd4
    } ddm_reg_idx_t;

    localparam logic [LEN_W-1:0]   AXLE_RST     = 16'd1024;
    localparam logic [LEN_W-1:0]   RADIUS_RST   = 16'd205;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 23'd81920;
    localparam logic [LEN_W-1:0]   STOPBAND_RST = 16'd4;
    localparam logic [LEN_W-1:0]   OBSTDIST_RST = 16'd512;

    localparam logic [LIM_W-1:0]   SPEED_TOP    = '1;

    typedef struct packed {
        logic                    action;
        logic signed [VEL_W-1:0] linear_vel;
        logic signed [VEL_W-1:0] angular_vel;
        logic [LEN_W-1:0]        range_value;
        logic [LEN_W-1:0]        range_min;
        logic [LEN_W-1:0]        range_max;
    } ddm_req_t;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] right_speed;
        logic signed [SPEED_WIDTH-1:0] left_speed;
        logic                          halt;
    } ddm_res_t;

    typedef struct packed {
        logic load_req;
        logic mul;
        logic sum;
        logic div_start;
        logic cmd_commit;
        logic rng_clear;
        logic rng_emit;
    } ddm_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic rng_valid;
        logic rng_hit;
        logic out_free;
    } ddm_status_t;

endpackage

/* design/ddm_div.sv */
// Restoring serial divider: magnitude of a signed numerator over an unsigned divisor,
// one quotient bit per cycle. Uses ddm_pkg.
module ddm_div
    import ddm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DIV_W-1:0]        divisor,
    output logic                    busy,
    output logic                    neg,
    output logic                    nonzero,
    output logic [NUM_W-1:0]        quo
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic             nz_reg, nz_next;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] diff;
    logic             ge;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
    assign ge     = !diff[DIV_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        nz_next   = nz_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS);
            quo_next  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_next  = '0;
            neg_next  = num[NUM_W-1];
            nz_next   = (num != '0);
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        nz_reg  <= nz_next;
    end

    assign busy    = busy_reg;
    assign neg     = neg_reg;
    assign nonzero = nz_reg;
    assign quo     = quo_reg;

endmodule

/* design/ddm_ctrl.sv */
// Sequencing state machine: request intake, multiply, add, divide, commit; range checks.
// Drives datapath commands, reads datapath status. Uses ddm_pkg.
module ddm_ctrl
    import ddm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_action,
    output logic        req_stall,
    input  ddm_status_t status,
    output ddm_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_LOAD = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_RNG  = 7'b1000000
    } ddm_state_t;

    ddm_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = req_action ? S_RNG : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.cmd_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RNG:
            begin
                if (status.rng_hit)
                begin
                    // obstacle: wait for the output register, then re-emit with halt
                    if (status.out_free)
                    begin
                        cmd.rng_emit = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rng_clear = status.rng_valid;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

/* design/ddm_dp.sv */
// Datapath: config registers, request capture, w*axle multiply, numerator add,
// two serial dividers, clamp, stop logic, held state and result register. Uses ddm_pkg.
module ddm_dp
    import ddm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ddm_req_t              req,
    output ddm_res_t              res,
    output logic                  res_valid,
    input  logic                  res_stall,
    input  ddm_cmd_t              cmd,
    output ddm_status_t           status
);

    // configuration
    logic [LEN_W-1:0]   axle_reg, radius_reg, stopband_reg, obstdist_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // captured request
    logic signed [VEL_W-1:0] v_reg, w_reg;
    logic [LEN_W-1:0]        rv_reg, rmin_reg, rmax_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NUM_W-1:0]  num_r_reg, num_l_reg;

    // held state
    logic signed [SPEED_WIDTH-1:0] held_r_reg, held_l_reg;
    logic                          obst_reg, fwd_reg;

    ddm_res_t res_reg;
    logic     res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axle_reg     <= AXLE_RST;
            radius_reg   <= RADIUS_RST;
            limit_reg    <= LIMIT_RST;
            stopband_reg <= STOPBAND_RST;
            obstdist_reg <= OBSTDIST_RST;
        end
        else if (cfg_we)
        begin
            unique case (ddm_reg_idx_t'(cfg_index))
                REG_AXLE:     axle_reg     <= cfg_data[LEN_W-1:0];
                REG_RADIUS:   radius_reg   <= cfg_data[LEN_W-1:0];
                REG_LIMIT:    limit_reg    <= cfg_data[LIMIT_W-1:0];
                REG_STOPBAND: stopband_reg <= cfg_data[LEN_W-1:0];
                REG_OBSTDIST: obstdist_reg <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // multiply and add
    logic signed [NUM_W-1:0]          prod_full;
    logic signed [VEL_W+VS_SHIFT-1:0] vs;

    assign prod_full = w_reg * $signed({1'b0, axle_reg});
    assign vs        = {v_reg, VS_SHIFT'(0)};

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            v_reg    <= req.linear_vel;
            w_reg    <= req.angular_vel;
            rv_reg   <= req.range_value;
            rmin_reg <= req.range_min;
            rmax_reg <= req.range_max;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (cmd.sum)
        begin
            num_r_reg <= NUM_W'(vs) + NUM_W'(prod_reg);
            num_l_reg <= NUM_W'(vs) - NUM_W'(prod_reg);
        end
    end

    // dividers, divisor is 2*radius
    logic [DIV_W-1:0] divisor;
    logic             busy_r, busy_l, neg_r, neg_l, nz_r, nz_l;
    logic [NUM_W-1:0] quo_r, quo_l;

    assign divisor = {radius_reg, 1'b0};

    ddm_div u_div_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (num_r_reg),
        .divisor (divisor),
        .busy    (busy_r),
        .neg     (neg_r),
        .nonzero (nz_r),
        .quo     (quo_r)
    );

    ddm_div u_div_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (num_l_reg),
        .divisor (divisor),
        .busy    (busy_l),
        .neg     (neg_l),
        .nonzero (nz_l),
        .quo     (quo_l)
    );

    // clamp: limit never exceeds the largest positive speed
    localparam int CMP_W = (LIMIT_W > LIM_W) ? LIMIT_W : LIM_W;

    logic [LIM_W-1:0] eff_lim;
    logic [LIM_W-1:0] q_r, q_l;
    logic signed [SPEED_WIDTH-1:0] speed_r, speed_l;
    logic halt_cmd, fwd_cmd;

    assign eff_lim = (CMP_W'(limit_reg) < CMP_W'(SPEED_TOP)) ?
                     LIM_W'(limit_reg) : SPEED_TOP;

    always_comb
    begin
        // zero radius saturates the quotient
        if (radius_reg == '0)
        begin
            q_r = nz_r ? eff_lim : '0;
            q_l = nz_l ? eff_lim : '0;
        end
        else
        begin
            q_r = (quo_r > NUM_W'(eff_lim)) ? eff_lim : quo_r[LIM_W-1:0];
            q_l = (quo_l > NUM_W'(eff_lim)) ? eff_lim : quo_l[LIM_W-1:0];
        end
    end

    assign speed_r  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    assign speed_l  = neg_l ? -$signed({1'b0, q_l}) : $signed({1'b0, q_l});
    assign fwd_cmd  = !v_reg[VEL_W-1] && (v_reg != '0);
    assign halt_cmd = ((q_r <= LIM_W'(stopband_reg)) && (q_l <= LIM_W'(stopband_reg)))
                      || (obst_reg && fwd_cmd);

    // range reading
    logic rng_valid, rng_hit;

    assign rng_valid = (rv_reg > rmin_reg) && (rv_reg < rmax_reg);
    assign rng_hit   = rng_valid && fwd_reg && (rv_reg < obstdist_reg);

    // held state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_r_reg    <= '0;
            held_l_reg    <= '0;
            obst_reg      <= 1'b1;
            fwd_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cmd_commit)
            begin
                held_r_reg <= speed_r;
                held_l_reg <= speed_l;
                fwd_reg    <= fwd_cmd;
            end
            if (cmd.rng_emit)
            begin
                obst_reg <= 1'b1;
            end
            else if (cmd.rng_clear)
            begin
                obst_reg <= 1'b0;
            end
            if (cmd.cmd_commit || cmd.rng_emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmd_commit)
        begin
            res_reg.right_speed <= speed_r;
            res_reg.left_speed  <= speed_l;
            res_reg.halt        <= halt_cmd;
        end
        else if (cmd.rng_emit)
        begin
            res_reg.right_speed <= held_r_reg;
            res_reg.left_speed  <= held_l_reg;
            res_reg.halt        <= 1'b1;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    assign status.div_busy  = busy_r || busy_l;
    assign status.rng_valid = rng_valid;
    assign status.rng_hit   = rng_hit;
    assign status.out_free  = !res_valid_reg || !res_stall;

endmodule

/* design/diff_drive_mixer_with_obstacle_stop_unit.sv */
// Velocity command: multiply, add, divider load, 41 divider steps, done check, commit.
// Range reading: an obstacle result, if any, follows the check of the captured reading.
// One request at a time: req_stall holds the input until a command commits or a reading
// is checked, longer while a finished result waits on res_stall.
// Reset (rst_n, async active low): config registers to defaults, held speeds zero,
// obstacle flag set, no result pending.
module diff_drive_mixer_with_obstacle_stop_unit
    import ddm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ddm_req_t              req,
    output logic                  res_valid,
    input  logic                  res_stall,
    output ddm_res_t              res
);

    ddm_cmd_t    cmd;
    ddm_status_t status;

    ddm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .req_stall  (req_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ddm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* design/ddm_checker.sv */
// Port-level checks for the mixer top level, attached by bind.
// Uses ddm_pkg; depends on diff_drive_mixer_with_obstacle_stop_unit.
module ddm_checker
    import ddm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input ddm_req_t req,
    input logic     res_valid,
    input logic     res_stall,
    input ddm_res_t res
);

    // every accepted request stalls the input in the following cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted back to back");

    // a velocity command cannot produce a result too early
    a_cmd_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !req.action |=> !$rose(res_valid) ##1 !$rose(res_valid))
        else $error("velocity result too early");

    // a result that follows a range reading directly is an obstacle stop
    a_range_halts: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.action |=> ##1 ($rose(res_valid) |-> res.halt))
        else $error("range result without halt");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind diff_drive_mixer_with_obstacle_stop_unit ddm_checker u_ddm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

/* dv/ddm_setpoint_checker.sv */
// Setpoint checker for the differential-drive mixer: follows register writes and requests,
// predicts each wheel-speed result and compares it with what the unit hands back.
// Depends on ddm_pkg.
module ddm_setpoint_checker
    import ddm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  ddm_req_t              req,
    input  logic                  res_valid,
    input  logic                  res_stall,
    input  ddm_res_t              res,
    output int                    pending,
    output int                    errors
);

    logic [LEN_W-1:0]              axle_len;
    logic [LEN_W-1:0]              radius_len;
    logic [LIMIT_W-1:0]            speed_cap;
    logic [LEN_W-1:0]              stop_band;
    logic [LEN_W-1:0]              obst_dist;
    logic signed [SPEED_WIDTH-1:0] right_held;
    logic signed [SPEED_WIDTH-1:0] left_held;
    logic                          halt_held;
    logic                          obstacle_flag;
    logic                          fwd_motion;
    ddm_res_t                      setpoints_due[$];
    int                            mismatch_cnt;

    // num carries the wheel numerator at Q.25, so the divisor is twice the radius
    function automatic logic signed [SPEED_WIDTH-1:0] wheel_rate(input longint num);
        longint unsigned               mag;
        longint unsigned               divisor;
        longint unsigned               cap;
        longint unsigned               quot;
        logic signed [SPEED_WIDTH-1:0] q;
        mag     = (num < 0) ? -num : num;
        divisor = {radius_len, 1'b0};
        cap     = (speed_cap < SPEED_TOP) ? speed_cap : SPEED_TOP;
        if (divisor == 0)
            quot = (mag != 0) ? cap : 0;
        else
            quot = mag / divisor;
        if (quot > cap)
            quot = cap;
        q = quot[SPEED_WIDTH-1:0];
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint speed_mag(input logic signed [SPEED_WIDTH-1:0] s);
        longint x;
        x = s;
        return (x < 0) ? -x : x;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_AXLE:     axle_len   = val[LEN_W-1:0];
            REG_RADIUS:   radius_len = val[LEN_W-1:0];
            REG_LIMIT:    speed_cap  = val[LIMIT_W-1:0];
            REG_STOPBAND: stop_band  = val[LEN_W-1:0];
            REG_OBSTDIST: obst_dist  = val[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void mix_request(input ddm_req_t r);
        longint   v;
        longint   w;
        longint   scaled_v;
        longint   turn;
        ddm_res_t sp;
        if (r.action != ACT_RANGE)
        begin
            v        = $signed(r.linear_vel);
            w        = $signed(r.angular_vel);
            scaled_v = v <<< VS_SHIFT;
            turn     = w * longint'(axle_len);
            right_held = wheel_rate(scaled_v + turn);
            left_held  = wheel_rate(scaled_v - turn);
            fwd_motion = (v > 0);
            halt_held  = (speed_mag(right_held) <= stop_band &&
                          speed_mag(left_held) <= stop_band) ||
                         (obstacle_flag && fwd_motion);
            sp.right_speed = right_held;
            sp.left_speed  = left_held;
            sp.halt        = halt_held;
            setpoints_due.push_back(sp);
        end
        else if (r.range_value > r.range_min && r.range_value < r.range_max)
        begin
            if (fwd_motion && r.range_value < obst_dist)
            begin
                // obstacle ahead: re-send the held speeds with halt
                obstacle_flag  = 1'b1;
                halt_held      = 1'b1;
                sp.right_speed = right_held;
                sp.left_speed  = left_held;
                sp.halt        = 1'b1;
                setpoints_due.push_back(sp);
            end
            else
            begin
                obstacle_flag = 1'b0;
            end
        end
    endfunction

    function automatic void check_field(input string field,
                                        input logic signed [SPEED_WIDTH-1:0] want,
                                        input logic signed [SPEED_WIDTH-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_cnt++;
        end
    endfunction

    function automatic void compare_setpoint(input ddm_res_t got);
        ddm_res_t want;
        if (setpoints_due.size() == 0)
        begin
            $display("%0t: result with none expected, actual right %0d left %0d halt %0b",
                     $time, got.right_speed, got.left_speed, got.halt);
            mismatch_cnt++;
        end
        else
        begin
            want = setpoints_due.pop_front();
            check_field("right_speed", want.right_speed, got.right_speed);
            check_field("left_speed", want.left_speed, got.left_speed);
            check_field("halt", want.halt, got.halt);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axle_len      = AXLE_RST;
            radius_len    = RADIUS_RST;
            speed_cap     = LIMIT_RST;
            stop_band     = STOPBAND_RST;
            obst_dist     = OBSTDIST_RST;
            right_held    = '0;
            left_held     = '0;
            halt_held     = 1'b0;
            obstacle_flag = 1'b1;
            fwd_motion    = 1'b0;
            mismatch_cnt  = 0;
            setpoints_due.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            // results first so a new request never satisfies an early result
            if (res_valid && !res_stall)
                compare_setpoint(res);
            if (cfg_we)
                store_reg(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                mix_request(req);
            pending <= setpoints_due.size();
            errors  <= mismatch_cnt;
        end
    end

endmodule

/* dv/tb_diff_drive_mixer_with_obstacle_stop_unit.sv */
// Top of the mixer testbench: clock, reset, register setup, request traffic and result
// back-pressure; the verdict comes from ddm_setpoint_checker.
// Depends on ddm_pkg, ddm_setpoint_checker and diff_drive_mixer_with_obstacle_stop_unit.
module tb_diff_drive_mixer_with_obstacle_stop_unit;
    import ddm_pkg::*;

    localparam int   PAD_W           = CFG_DATA_W - LEN_W;
    localparam int   PHASES          = 8;
    localparam int   ITEMS_PER_PHASE = 110;
    localparam int   SQUEEZE_PHASE   = 2;
    localparam int   LONG_HOLD       = 400;
    localparam int   DRAIN_CYCLES    = 60;
    localparam int   VEL_MAX         = 8388607;
    localparam int   VEL_MIN         = -8388608;
    localparam int   LEN_MAX         = 65535;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_stall;
    ddm_req_t              req;
    logic                  res_valid;
    logic                  res_stall;
    ddm_res_t              res;
    int                    pending;
    int                    errors;
    logic                  squeeze;
    logic                  calm;
    logic [LEN_W-1:0]      obst_now;

    diff_drive_mixer_with_obstacle_stop_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    ddm_setpoint_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .pending   (pending),
        .errors    (errors)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stall bursts, quiet stretches, one long hold-off
    initial
    begin
        bit squeezed;
        squeezed  = 1'b0;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                res_stall <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    task automatic put_reg(input ddm_reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // unused upper data bits get junk on the 16-bit registers
    task automatic program_regs(input logic [LEN_W-1:0] axle, input logic [LEN_W-1:0] radius,
                                input logic [LIMIT_W-1:0] cap, input logic [LEN_W-1:0] band,
                                input logic [LEN_W-1:0] obst);
        put_reg(REG_AXLE, {PAD_W'($urandom()), axle});
        put_reg(REG_RADIUS, {PAD_W'($urandom()), radius});
        put_reg(REG_LIMIT, cap);
        put_reg(REG_STOPBAND, {PAD_W'($urandom()), band});
        put_reg(REG_OBSTDIST, {PAD_W'($urandom()), obst});
        cfg_we   <= 1'b0;
        obst_now = obst;
    endtask

    task automatic send(input ddm_req_t item);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // range readings without an obstacle yield no result, so allow the pipeline to empty after the last one
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic ddm_req_t vel_cmd(input int v, input int w);
        ddm_req_t it;
        it.action      = ACT_VEL;
        it.linear_vel  = v[VEL_W-1:0];
        it.angular_vel = w[VEL_W-1:0];
        it.range_value = LEN_W'($urandom());
        it.range_min   = LEN_W'($urandom());
        it.range_max   = LEN_W'($urandom());
        return it;
    endfunction

    function automatic ddm_req_t range_read(input int r, input int lo, input int hi);
        ddm_req_t it;
        it.action      = ACT_RANGE;
        it.linear_vel  = VEL_W'($urandom());
        it.angular_vel = VEL_W'($urandom());
        it.range_value = r[LEN_W-1:0];
        it.range_min   = lo[LEN_W-1:0];
        it.range_max   = hi[LEN_W-1:0];
        return it;
    endfunction

    function automatic int random_velocity();
        case ($urandom_range(0, 9))
            0, 1:    return $signed(VEL_W'($urandom()));
            2:       return 0;
            3:       return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom_range(0, 16384)) - 8192;
        endcase
    endfunction

    // commands and mostly well-formed readings, most near the obstacle distance, some noise
    function automatic ddm_req_t random_item();
        int r;
        if ($urandom_range(0, 99) < 40)
            return vel_cmd(random_velocity(), random_velocity());
        if ($urandom_range(0, 6) == 0)
            return range_read($urandom_range(0, LEN_MAX), $urandom_range(0, LEN_MAX),
                              $urandom_range(0, LEN_MAX));
        if ($urandom_range(0, 3) == 0)
        begin
            r = $urandom_range(1, LEN_MAX - 1);
        end
        else
        begin
            r = int'(obst_now) + int'($urandom_range(0, 128)) - 64;
            if (r < 1)
                r = 1;
            if (r > LEN_MAX - 1)
                r = LEN_MAX - 1;
        end
        return range_read(r, $urandom_range(0, r - 1), $urandom_range(r + 1, LEN_MAX));
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_AXLE;
        cfg_data  = '0;
        req_valid = 1'b0;
        req       = '0;
        squeeze   = 1'b0;
        calm      = 1'b0;
        obst_now  = OBSTDIST_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, obstacle flag starts set
        send(vel_cmd(0, 0));                // inside stop band
        send(vel_cmd(4096, 0));             // forward with flag set from reset
        send(range_read(1000, 100, 2000));  // clear reading
        send(vel_cmd(4096, 0));
        send(range_read(300, 100, 2000));   // obstacle while moving forward
        send(range_read(300, 300, 2000));   // on the lower bound
        send(range_read(300, 100, 300));    // on the upper bound
        send(range_read(300, 2000, 100));   // bounds swapped
        send(range_read(300, 300, 300));
        send(vel_cmd(VEL_MAX, 0));
        send(range_read(LEN_MAX - 1, 0, LEN_MAX));
        send(vel_cmd(VEL_MAX, VEL_MAX));
        send(vel_cmd(VEL_MIN, VEL_MIN));
        send(vel_cmd(VEL_MIN, VEL_MAX));
        send(vel_cmd(-1, 0));
        send(vel_cmd(1, -1));
        send(vel_cmd(0, VEL_MAX));
        send(range_read(100, 0, LEN_MAX));  // near reading but not moving forward
        send(range_read(0, 0, LEN_MAX));
        send(range_read(LEN_MAX, 0, LEN_MAX));
        send(vel_cmd(8192, 4096));
        send(range_read(511, 510, 512));    // just under the obstacle distance
        send(range_read(512, 510, 600));    // exactly at it
        send(vel_cmd(8192, -4096));
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: program_regs(LEN_W'(1), LEN_W'(1), LIMIT_W'(0), LEN_W'(0), LEN_W'(0));
                1: program_regs(LEN_W'(LEN_MAX), LEN_W'(LEN_MAX), SPEED_TOP,
                                LEN_W'(LEN_MAX), LEN_W'(LEN_MAX));
                2: program_regs(AXLE_RST, LEN_W'(0), LIMIT_RST, STOPBAND_RST, OBSTDIST_RST);
                default:
                    program_regs(LEN_W'($urandom_range(0, 1) ? $urandom_range(1, LEN_MAX)
                                                             : $urandom_range(256, 4096)),
                                 LEN_W'($urandom_range(0, 1) ? $urandom_range(1, LEN_MAX)
                                                             : $urandom_range(64, 1024)),
                                 LIMIT_W'($urandom_range(0, 1) ? $urandom_range(0, SPEED_TOP)
                                                               : $urandom_range(40000, 200000)),
                                 LEN_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, LEN_MAX)
                                                                  : $urandom_range(0, 64)),
                                 LEN_W'($urandom_range(0, LEN_MAX)));
            endcase
            if (phase == SQUEEZE_PHASE)
                squeeze <= 1'b1;
            if (phase == PHASES - 1)
                calm <= 1'b1;
            repeat (ITEMS_PER_PHASE) send(random_item());
            settle();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
